// ===== hdl/assert_macros.svh =====
// Assertion helpers for files that check their own logic; the core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, skipped while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/grm_pkg.sv =====
// ----------------------------------------------------------------------------
// grm_pkg
// Types, codes and the quarter-wave sine generator of the grid ray marcher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_PLAYER_X  = 2'd0,
    REG_PLAYER_Y  = 2'd1,
    REG_WALL_LOW  = 2'd2,
    REG_WALL_HIGH = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_WALL = 2'd1,
    KIND_EXIT = 2'd2
  } step_kind_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_ANGLE,
    F_COS,
    F_SIN,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_STEP
  } back_state_t;

  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS);

  // Unit step of one ray, Q1.10 signed.
  typedef struct packed {
    logic signed [11:0] dx;
    logic signed [11:0] dy;
  } ray_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic [4:0] cell_col;
    logic [4:0] cell_row;
    step_kind_t step_kind;
    logic       last;
  } result_t;

  // Q30 coefficients of sin(pi/2 * x) on [0,1].
  localparam logic [63:0] C1 = 64'd1686629713;
  localparam logic [63:0] C3 = 64'd693598668;
  localparam logic [63:0] C5 = 64'd85569306;
  localparam logic [63:0] C7 = 64'd5026994;
  localparam logic [63:0] C9 = 64'd172272;

  // Table entry k of the quarter wave, evaluated at elaboration only.
  function automatic logic [10:0] quarter_sin(input int unsigned k,
                                              input int unsigned abits);
    logic [63:0] xq;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    xq = 64'(k) << (32 - abits);
    x2 = (xq * xq) >> 30;
    t  = C9;
    t  = C7 - ((x2 * t) >> 30);
    t  = C5 - ((x2 * t) >> 30);
    t  = C3 - ((x2 * t) >> 30);
    t  = C1 - ((x2 * t) >> 30);
    s  = (xq * t) >> 30;
    s  = (s + (64'd1 << 19)) >> 20;
    if (s > 64'd1024) s = 64'd1024;
    return s[10:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/grm_front.sv =====
// ----------------------------------------------------------------------------
// grm_front
// Takes a command word, forms the ray angle and looks up its unit step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grm_front
  import grm_pkg::*;
#(
  parameter int RAY_COUNT  = 20,
  parameter int ANGLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [9:0]  player_angle,
  input  wire logic [4:0]  ray_index,
  input  wire queue_stat_t q_stat,
  output      logic        busy,
  output      logic        push,
  output      ray_t        push_ray
);

  localparam int ANGLE_UNITS = 2 ** ANGLE_BITS;
  localparam int QUARTER     = 2 ** (ANGLE_BITS - 2);
  localparam int FOV_UNITS   = (ANGLE_UNITS + 3) / 6;
  localparam int TI_W        = ANGLE_BITS - 1;
  localparam int RI_W        = $clog2(RAY_COUNT);

  front_state_t state, state_next;

  logic [ANGLE_BITS-1:0] head;
  logic [4:0]            idx;
  logic [ANGLE_BITS-1:0] ang;
  logic signed [11:0]    dx;
  logic signed [11:0]    dy;

  logic [10:0]           sin_tab [QUARTER+1];
  logic [ANGLE_BITS-1:0] off_tab [RAY_COUNT];

  // Quarter-wave sine table and the angle offset of each ray.
  for (genvar g = 0; g <= QUARTER; g++) begin : g_sin
    localparam logic [10:0] T_G = quarter_sin(g, ANGLE_BITS);
    assign sin_tab[g] = T_G;
  end

  for (genvar g = 0; g < RAY_COUNT; g++) begin : g_off
    localparam int OFF_G = (FOV_UNITS * g * 2 + (RAY_COUNT - 1)) / (2 * (RAY_COUNT - 1));
    assign off_tab[g] = ANGLE_BITS'(OFF_G);
  end

  logic [6:0]            idx_c;
  logic [ANGLE_BITS-1:0] ang_next;
  logic [ANGLE_BITS-1:0] look_arg;
  logic [TI_W-1:0]       tab_idx;
  logic [10:0]           mag;
  logic signed [11:0]    look_val;
  logic                  look_cos;

  always_comb begin
    idx_c = {2'b00, idx};
    if (idx_c > 7'(RAY_COUNT - 1)) idx_c = 7'(RAY_COUNT - 1);
    ang_next = head - ANGLE_BITS'(FOV_UNITS / 2) + off_tab[idx_c[RI_W-1:0]];
  end

  // One shared lookup: cosine is the sine a quarter turn ahead.
  always_comb begin
    look_arg = look_cos ? (ang + ANGLE_BITS'(QUARTER)) : ang;
    tab_idx  = look_arg[ANGLE_BITS-2]
             ? (TI_W'(QUARTER) - TI_W'(look_arg[ANGLE_BITS-3:0]))
             : TI_W'(look_arg[ANGLE_BITS-3:0]);
    mag      = sin_tab[tab_idx];
    look_val = look_arg[ANGLE_BITS-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:  if (start) state_next = F_ANGLE;
      F_ANGLE: state_next = F_COS;
      F_COS:   state_next = F_SIN;
      F_SIN:   state_next = F_PUSH;
      F_PUSH:  if (!q_stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != F_IDLE);
    look_cos = (state == F_COS);
    push     = (state == F_PUSH) && !q_stat.full;
    push_ray = '{dx: dx, dy: dy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      head <= ANGLE_BITS'(player_angle);
      idx  <= ray_index;
    end
    if (state == F_ANGLE) ang <= ang_next;
    if (state == F_COS) dx <= look_val;
    if (state == F_SIN) dy <= look_val;
  end

endmodule

`default_nettype wire

// ===== hdl/grm_queue.sv =====
// ----------------------------------------------------------------------------
// grm_queue
// Two-entry queue of ray steps between the front and the marching back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grm_queue
  import grm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire ray_t        push_ray,
  input  wire logic        pop,
  output      ray_t        pop_ray,
  output      queue_stat_t q_stat
);

  ray_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_comb begin
    q_stat.full  = (count == 2'd2);
    q_stat.empty = (count == 2'd0);
    pop_ray      = slot[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_ray;
  end

endmodule

`default_nettype wire

// ===== hdl/grm_back.sv =====
// ----------------------------------------------------------------------------
// grm_back
// Marches one ray across the grid, one unit step and one result per cycle while in B_STEP.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grm_back
  import grm_pkg::*;
#(
  parameter int MAP_W = 10,
  parameter int MAP_H = 10
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire queue_stat_t            q_stat,
  input  wire ray_t                   pop_ray,
  input  wire logic [13:0]            player_x,
  input  wire logic [13:0]            player_y,
  input  wire logic [MAP_W*MAP_H-1:0] wall_cells,
  output      logic                   pop,
  output      logic                   result_valid,
  output      result_t                result
);

  localparam int CI_W = $clog2(MAP_W * MAP_H);

  back_state_t state, state_next;

  logic signed [15:0] march_x;
  logic signed [15:0] march_y;
  logic signed [11:0] dx;
  logic signed [11:0] dy;
  logic [CNT_W-1:0]   n;

  logic signed [15:0] tx;
  logic signed [15:0] ty;
  logic signed [5:0]  col;
  logic signed [5:0]  row;
  logic               on_map;
  logic [7:0]         lin;
  step_kind_t         kind;
  logic               stop;

  function automatic logic [4:0] sat5(input logic signed [5:0] c);
    if (c[5] == c[4]) return c[4:0];
    return c[5] ? 5'b10000 : 5'b01111;
  endfunction

  // Truncation toward zero: bias negative positions before the shift.
  always_comb begin
    tx     = march_x + (march_x[15] ? 16'sd1023 : 16'sd0);
    ty     = march_y + (march_y[15] ? 16'sd1023 : 16'sd0);
    col    = tx[15:10];
    row    = ty[15:10];
    on_map = !col[5] && (col[4:0] < 5'(MAP_W)) && !row[5] && (row[4:0] < 5'(MAP_H));
    lin    = 8'(row[3:0]) * 8'(MAP_W) + 8'(col[3:0]);
    if (!on_map)                      kind = KIND_EXIT;
    else if (wall_cells[lin[CI_W-1:0]]) kind = KIND_WALL;
    else                              kind = KIND_FREE;
    // The result budget ends a ray that is still running.
    if (kind == KIND_FREE && n == CNT_W'(MAX_RESULTS - 1)) kind = KIND_EXIT;
    stop = (kind != KIND_FREE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!q_stat.empty) state_next = B_STEP;
      B_STEP:  if (stop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == B_IDLE) && !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      march_x      <= '0;
      march_y      <= '0;
    end else begin
      state        <= state_next;
      result_valid <= (state == B_STEP);
      if (pop) begin
        march_x <= $signed({2'b00, player_x}) + 16'(pop_ray.dx);
        march_y <= $signed({2'b00, player_y}) + 16'(pop_ray.dy);
      end else if (state == B_STEP) begin
        march_x <= march_x + 16'(dx);
        march_y <= march_y + 16'(dy);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      dx <= pop_ray.dx;
      dy <= pop_ray.dy;
      n  <= '0;
    end else if (state == B_STEP) begin
      n <= n + CNT_W'(1);
    end
    if (state == B_STEP) begin
      result.cell_col  <= sat5(col);
      result.cell_row  <= sat5(row);
      result.step_kind <= kind;
      result.last      <= stop;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/grid_ray_march_core.sv =====
// ----------------------------------------------------------------------------
// grid_ray_march_core
// Fixed-step ray marcher over a grid of wall bits, one ray per command word.
// ----------------------------------------------------------------------------
// A taken start walks the front through F_ANGLE, F_COS, F_SIN and F_PUSH,
// which waits while the queue is full; the back end pops the ray, then gives
// one result per cycle until the final one (at most 16 results per ray).
// The front can take a new start while the back end still marches a ray.
// Reset (rst, synchronous) empties the queue, idles both halves and loads
// the register reset values; results are never stalled by the receiver.
`timescale 1ns / 1ps
`default_nettype none

module grid_ray_march_core
  import grm_pkg::*;
#(
  parameter int MAP_W      = 10,
  parameter int MAP_H      = 10,
  parameter int RAY_COUNT  = 20,
  parameter int ANGLE_BITS = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [63:0] cfg_data,
  input  wire logic        start,
  input  wire logic [9:0]  player_angle,
  input  wire logic [4:0]  ray_index,
  output      logic        busy,
  output      logic        result_valid,
  output      logic [4:0]  cell_col,
  output      logic [4:0]  cell_row,
  output      logic [1:0]  step_kind,
  output      logic        last
);

  logic [13:0] player_x;
  logic [13:0] player_y;
  logic [63:0] wall_map_low;
  logic [35:0] wall_map_high;
  logic [99:0] wall_vec;

  queue_stat_t q_stat;
  ray_t        push_ray;
  ray_t        pop_ray;
  logic        push;
  logic        pop;
  result_t     result;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= 14'd5120;
      player_y      <= 14'd5120;
      wall_map_low  <= '0;
      wall_map_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_PLAYER_X:  player_x      <= cfg_data[13:0];
        REG_PLAYER_Y:  player_y      <= cfg_data[13:0];
        REG_WALL_LOW:  wall_map_low  <= cfg_data;
        REG_WALL_HIGH: wall_map_high <= cfg_data[35:0];
        default: ;
      endcase
    end
  end

  assign wall_vec = {wall_map_high, wall_map_low};

  grm_front #(
    .RAY_COUNT  (RAY_COUNT),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .player_angle (player_angle),
    .ray_index    (ray_index),
    .q_stat       (q_stat),
    .busy         (busy),
    .push         (push),
    .push_ray     (push_ray)
  );

  grm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_ray (push_ray),
    .pop      (pop),
    .pop_ray  (pop_ray),
    .q_stat   (q_stat)
  );

  grm_back #(
    .MAP_W (MAP_W),
    .MAP_H (MAP_H)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .pop_ray      (pop_ray),
    .player_x     (player_x),
    .player_y     (player_y),
    .wall_cells   (wall_vec[MAP_W*MAP_H-1:0]),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result)
  );

  assign cell_col  = result.cell_col;
  assign cell_row  = result.cell_row;
  assign step_kind = result.step_kind;
  assign last      = result.last;

`include "assert_macros.svh"

  `ASSERT_IMPLY(a_no_overflow, clk, rst, push, !q_stat.full, "queue written while full")
  `ASSERT_IMPLY(a_no_underflow, clk, rst, pop, !q_stat.empty, "queue read while empty")
  `ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy, "start not held off")
  `ASSERT_NEXT(a_ray_contiguous, clk, rst, result_valid && !last, result_valid,
               "gap inside a ray's results")

endmodule

`default_nettype wire

// ===== test/ray_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_result_checker
// Watches the command, register and result channels of the ray marcher,
// works out the cells each accepted ray must report and compares every
// result word with the oldest cell still waiting.
// ----------------------------------------------------------------------------

module ray_result_checker
  import grm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_data,
  input  logic        start,
  input  logic        busy,
  input  logic [9:0]  player_angle,
  input  logic [4:0]  ray_index,
  input  logic        result_valid,
  input  logic [4:0]  cell_col,
  input  logic [4:0]  cell_row,
  input  logic [1:0]  step_kind,
  input  logic        last,
  output int          fail_count,
  output int          cells_waiting
);

  localparam int MAP_W       = 10;
  localparam int MAP_H       = 10;
  localparam int RAY_COUNT   = 20;
  localparam int ANGLE_BITS  = 10;
  localparam int ANGLE_UNITS = 1 << ANGLE_BITS;
  localparam int QUARTER     = ANGLE_UNITS / 4;
  localparam int FOV_UNITS   = (ANGLE_UNITS + 3) / 6;

  // Odd polynomial of sin(pi/2 * x) on [0,1], Q30.
  localparam logic [63:0] SIN_K1 = 64'd1686629713;
  localparam logic [63:0] SIN_K3 = 64'd693598668;
  localparam logic [63:0] SIN_K5 = 64'd85569306;
  localparam logic [63:0] SIN_K7 = 64'd5026994;
  localparam logic [63:0] SIN_K9 = 64'd172272;

  int          mismatches = 0;
  int          waiting_now = 0;
  int          start_x = 5120;
  int          start_y = 5120;
  logic [99:0] walls = '0;
  result_t     expected_cells[$];

  assign fail_count    = mismatches;
  assign cells_waiting = waiting_now;

  function automatic int wave_mag(input int k);
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] acc;
    u   = 64'(k) << (32 - ANGLE_BITS);
    u2  = (u * u) >> 30;
    acc = SIN_K9;
    acc = SIN_K7 - ((u2 * acc) >> 30);
    acc = SIN_K5 - ((u2 * acc) >> 30);
    acc = SIN_K3 - ((u2 * acc) >> 30);
    acc = SIN_K1 - ((u2 * acc) >> 30);
    acc = (u * acc) >> 30;
    acc = (acc + 64'h80000) >> 20;
    if (acc > 64'd1024) acc = 64'd1024;
    return int'(acc);
  endfunction

  function automatic int ray_sin(input int a);
    int q;
    int k;
    int m;
    a = a & (ANGLE_UNITS - 1);
    q = a >> (ANGLE_BITS - 2);
    k = a & (QUARTER - 1);
    m = ((q & 1) != 0) ? wave_mag(QUARTER - k) : wave_mag(k);
    return ((q & 2) != 0) ? -m : m;
  endfunction

  function automatic logic [4:0] clamp_cell(input int c);
    if (c < -16) c = -16;
    if (c > 15) c = 15;
    return c[4:0];
  endfunction

  // Queues every cell the ray reports, ending with the one that stops it.
  function automatic void predict_ray(input logic [9:0] heading, input logic [4:0] ridx);
    int         sel;
    int         off;
    int         ang;
    int         dx;
    int         dy;
    int         px;
    int         py;
    int         col;
    int         row;
    step_kind_t kind;
    result_t    exp_word;
    sel = int'(ridx);
    if (sel > RAY_COUNT - 1) sel = RAY_COUNT - 1;
    off = (FOV_UNITS * sel * 2 + RAY_COUNT - 1) / (2 * (RAY_COUNT - 1));
    ang = (int'(heading) + ANGLE_UNITS - FOV_UNITS / 2 + off) & (ANGLE_UNITS - 1);
    dx  = ray_sin(ang + QUARTER);
    dy  = ray_sin(ang);
    px  = start_x;
    py  = start_y;
    for (int n = 0; n < MAX_RESULTS; n++) begin
      px  = px + dx;
      py  = py + dy;
      col = px / 1024;
      row = py / 1024;
      if (col < 0 || col >= MAP_W || row < 0 || row >= MAP_H) kind = KIND_EXIT;
      else if (walls[row * MAP_W + col]) kind = KIND_WALL;
      else kind = KIND_FREE;
      // A ray that never stops is cut off on its last allowed word.
      if (kind == KIND_FREE && n == MAX_RESULTS - 1) kind = KIND_EXIT;
      exp_word.cell_col  = clamp_cell(col);
      exp_word.cell_row  = clamp_cell(row);
      exp_word.step_kind = kind;
      exp_word.last      = (kind != KIND_FREE);
      expected_cells.push_back(exp_word);
      if (kind != KIND_FREE) break;
    end
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      start_x = 5120;
      start_y = 5120;
      walls   = '0;
      expected_cells.delete();
    end else begin
      if (result_valid) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word, expected none, actual col %0d row %0d kind %0d last %0d",
                   $time, $signed(cell_col), $signed(cell_row), step_kind, last);
        end else begin
          want = expected_cells.pop_front();
          check_field("cell_col", int'($signed(want.cell_col)), int'($signed(cell_col)));
          check_field("cell_row", int'($signed(want.cell_row)), int'($signed(cell_row)));
          check_field("step_kind", int'(want.step_kind), int'(step_kind));
          check_field("last", int'(want.last), int'(last));
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_addr))
          REG_PLAYER_X:  start_x = int'(cfg_data[13:0]);
          REG_PLAYER_Y:  start_y = int'(cfg_data[13:0]);
          REG_WALL_LOW:  walls[63:0] = cfg_data;
          REG_WALL_HIGH: walls[99:64] = cfg_data[35:0];
          default: ;
        endcase
      end
      if (start && !busy) predict_ray(player_angle, ray_index);
    end
    waiting_now <= expected_cells.size();
  end

endmodule

// ===== test/tb_grid_ray_march_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_ray_march_core
// Drives rays into the grid ray marcher under a series of player positions
// and wall maps, with random gaps between command words in some segments;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------

module tb_grid_ray_march_core;
  import grm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_PLAYER_X;
  logic [63:0] cfg_data = '0;
  logic        start = 1'b0;
  logic [9:0]  player_angle = '0;
  logic [4:0]  ray_index = '0;
  logic        busy;
  logic        result_valid;
  logic [4:0]  cell_col;
  logic [4:0]  cell_row;
  logic [1:0]  step_kind;
  logic        last;
  int          fail_count;
  int          cells_waiting;
  int          idle_pct = 0;

  always #4 clk = ~clk;

  grid_ray_march_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .start        (start),
    .player_angle (player_angle),
    .ray_index    (ray_index),
    .busy         (busy),
    .result_valid (result_valid),
    .cell_col     (cell_col),
    .cell_row     (cell_row),
    .step_kind    (step_kind),
    .last         (last)
  );

  ray_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .start         (start),
    .busy          (busy),
    .player_angle  (player_angle),
    .ray_index     (ray_index),
    .result_valid  (result_valid),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .step_kind     (step_kind),
    .last          (last),
    .fail_count    (fail_count),
    .cells_waiting (cells_waiting)
  );

  // Each call begins and ends right after a rising edge.
  task automatic fire(input int angle, input int idx);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    player_angle <= angle[9:0];
    ray_index    <= idx[4:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (cells_waiting != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [13:0] px, input logic [13:0] py,
                           input logic [99:0] map);
    cfg_we   <= 1'b1;
    cfg_addr <= REG_PLAYER_X;
    cfg_data <= 64'(px);
    @(posedge clk);
    cfg_addr <= REG_PLAYER_Y;
    cfg_data <= 64'(py);
    @(posedge clk);
    cfg_addr <= REG_WALL_LOW;
    cfg_data <= map[63:0];
    @(posedge clk);
    cfg_addr <= REG_WALL_HIGH;
    cfg_data <= 64'(map[99:64]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Walls on the outer border of the ten by ten grid.
  function automatic logic [99:0] ring_map();
    logic [99:0] m;
    m = '0;
    for (int r = 0; r < 10; r++)
      for (int c = 0; c < 10; c++)
        if (r == 0 || r == 9 || c == 0 || c == 9) m[r * 10 + c] = 1'b1;
    return m;
  endfunction

  initial begin
    #3_000_000;
    $display("tb_grid_ray_march_core: FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [99:0] map;
    logic [13:0] px;
    logic [13:0] py;
    int          angle;
    int          idx;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Register reset values: open map, player in the middle.
    fire(0, 0);
    fire(1023, 19);
    fire(256, 31);
    fire(512, 20);
    fire(768, 10);
    fire(128, 5);
    fire(640, 9);
    wait_quiet();

    // Corner start; rays heading into negative space pass through cell 0.
    configure(14'd0, 14'd0, '0);
    fire(512, 0);
    fire(768, 19);
    fire(384, 10);
    fire(0, 0);
    fire(896, 31);
    wait_quiet();

    // Far corner with every cell a wall.
    configure(14'd10239, 14'd10239, '1);
    fire(0, 0);
    fire(256, 19);
    fire(640, 10);
    fire(900, 3);
    wait_quiet();

    configure(14'd5120, 14'd5120, ring_map());
    fire(0, 10);
    fire(256, 10);
    fire(512, 10);
    fire(768, 10);
    wait_quiet();

    for (int seg = 0; seg < 6; seg++) begin
      idle_pct = (seg < 2) ? 10 : (seg < 4) ? 64 : 0;
      case (seg % 3)
        0: map = 100'({$urandom, $urandom, $urandom, $urandom} &
                      {$urandom, $urandom, $urandom, $urandom} &
                      {$urandom, $urandom, $urandom, $urandom});
        1: map = ring_map() | 100'({$urandom, $urandom, $urandom, $urandom} &
                                   {$urandom, $urandom, $urandom, $urandom} &
                                   {$urandom, $urandom, $urandom, $urandom});
        default: map = 100'({$urandom, $urandom, $urandom, $urandom});
      endcase
      px = (seg == 1) ? 14'd0 : (seg == 4) ? 14'd10239 : 14'($urandom_range(10239));
      py = (seg == 1) ? 14'd10239 : (seg == 4) ? 14'd0 : 14'($urandom_range(10239));
      configure(px, py, map);
      for (int i = 0; i < 75; i++) begin
        angle = $urandom_range(1023);
        idx   = ($urandom_range(9) == 0) ? $urandom_range(31, 20) : $urandom_range(19);
        fire(angle, idx);
      end
      wait_quiet();
    end

    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_grid_ray_march_core: PASS");
    end else begin
      $display("tb_grid_ray_march_core: FAIL");
    end
    $finish;
  end

endmodule

// ===== grid_ray_march_core.f =====
+incdir+hdl
hdl/grm_pkg.sv
hdl/grm_front.sv
hdl/grm_queue.sv
hdl/grm_back.sv
hdl/grid_ray_march_core.sv
test/ray_result_checker.sv
test/tb_grid_ray_march_core.sv
